// File: rtl/core/cnv_pkg.sv
// ----------------------------------------------------------------------------
// cnv_pkg
// Shared types and constants for the 8x8 valid-region convolution stream.
// ----------------------------------------------------------------------------
package cnv_pkg;

   localparam int unsigned KSIZE      = 8;
   localparam int unsigned KAREA      = KSIZE * KSIZE;
   localparam int unsigned SAMPLE_W   = 16;
   localparam int unsigned IDX_W      = 10;
   localparam int unsigned SIZE_W     = 11;
   localparam int unsigned SUM_W      = 38;
   localparam int unsigned COEF_IDX_W = 6;
   localparam int unsigned MAX_WIDTH  = 1024;
   localparam int unsigned ADDR_W     = 10;
   localparam int unsigned PROD_W     = 2 * SAMPLE_W;
   localparam int unsigned PART_W     = PROD_W + 3;
   localparam int unsigned LINE_W     = (KSIZE - 1) * SAMPLE_W;

   localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(KSIZE);
   localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(MAX_WIDTH);
   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(8);
   localparam logic [SIZE_W-1:0] EDGE_LIM   = SIZE_W'(KSIZE - 1);

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_PIXEL = 1'b1
   } opcode_type;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      logic                  valid;
      logic                  pixel;
      logic                  emit;
      logic [COEF_IDX_W-1:0] coef_index;
      sample_type            value;
      logic [ADDR_W-1:0]     col;
      logic [IDX_W-1:0]      out_row;
      logic [IDX_W-1:0]      out_col;
   } stage_type;

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] out_row;
      logic [IDX_W-1:0] out_col;
   } tag_type;

endpackage

// File: rtl/core/cnv_if.sv
// ----------------------------------------------------------------------------
// cnv_if
// Request and response channel interfaces, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cnv_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [5:0]  coef_index;
   logic signed [15:0] value;

   modport source (output valid, opcode, coef_index, value, input ready);
   modport sink   (input valid, opcode, coef_index, value, output ready);
endinterface

interface cnv_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [37:0] sum;
   logic [9:0]  out_row;
   logic [9:0]  out_col;

   modport source (output valid, sum, out_row, out_col, input ready);
   modport sink   (input valid, sum, out_row, out_col, output ready);
endinterface

// File: rtl/core/cnv_window.sv
// ----------------------------------------------------------------------------
// cnv_window
// Line store memory (seven rows packed per column) and the 8x8 window.
// ----------------------------------------------------------------------------
module cnv_window (
   input  logic                           clock,
   input  logic                           adv,
   input  logic [cnv_pkg::ADDR_W-1:0]     rd_addr,
   input  cnv_pkg::stage_type             s1,
   output cnv_pkg::sample_type            win_o [cnv_pkg::KAREA]
);

   logic [cnv_pkg::LINE_W-1:0] mem [cnv_pkg::MAX_WIDTH];
   logic [cnv_pkg::LINE_W-1:0] rd_ff;
   logic [cnv_pkg::LINE_W-1:0] wr_data;
   cnv_pkg::sample_type        colvec [cnv_pkg::KSIZE];
   cnv_pkg::sample_type        win_ff [cnv_pkg::KSIZE][cnv_pkg::KSIZE];

   always_comb begin
      for (int r = 0; r < cnv_pkg::KSIZE - 1; r++) begin
         colvec[r] = rd_ff[r*cnv_pkg::SAMPLE_W +: cnv_pkg::SAMPLE_W];
      end
      colvec[cnv_pkg::KSIZE-1] = s1.value;
      for (int r = 0; r < cnv_pkg::KSIZE - 1; r++) begin
         wr_data[r*cnv_pkg::SAMPLE_W +: cnv_pkg::SAMPLE_W] = colvec[r+1];
      end
   end

   // consecutive pixels always hit different columns, so no read/write clash
   always_ff @(posedge clock) begin
      if (adv) begin
         rd_ff <= mem[rd_addr];
      end
      if (adv && s1.valid && s1.pixel) begin
         mem[s1.col] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && s1.valid && s1.pixel) begin
         for (int r = 0; r < cnv_pkg::KSIZE; r++) begin
            for (int k = 0; k < cnv_pkg::KSIZE - 1; k++) begin
               win_ff[r][k] <= win_ff[r][k+1];
            end
            win_ff[r][cnv_pkg::KSIZE-1] <= colvec[r];
         end
      end
   end

   always_comb begin
      for (int r = 0; r < cnv_pkg::KSIZE; r++) begin
         for (int k = 0; k < cnv_pkg::KSIZE; k++) begin
            win_o[r*cnv_pkg::KSIZE + k] = win_ff[r][k];
         end
      end
   end

endmodule

// File: rtl/core/cnv_mac.sv
// ----------------------------------------------------------------------------
// cnv_mac
// Kernel registers, 64 multipliers and a two-level registered adder tree.
// ----------------------------------------------------------------------------
module cnv_mac (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  cnv_pkg::stage_type                s1,
   input  cnv_pkg::sample_type               win_i [cnv_pkg::KAREA],
   output logic                              valid_o,
   output logic signed [cnv_pkg::SUM_W-1:0]  sum_o,
   output logic [cnv_pkg::IDX_W-1:0]         row_o,
   output logic [cnv_pkg::IDX_W-1:0]         col_o
);

   cnv_pkg::sample_type                kern_ff [cnv_pkg::KAREA];
   logic signed [cnv_pkg::PROD_W-1:0]  prod_ff [cnv_pkg::KAREA];
   logic signed [cnv_pkg::PART_W-1:0]  part_ff [cnv_pkg::KSIZE];
   logic signed [cnv_pkg::PART_W-1:0]  part_in [cnv_pkg::KSIZE];
   logic signed [cnv_pkg::SUM_W-1:0]   sum_ff, sum_in;
   cnv_pkg::tag_type                   t2_ff, t3_ff, t4_ff, t5_ff;

   always_ff @(posedge clock) begin
      if (adv && s1.valid && !s1.pixel) begin
         kern_ff[s1.coef_index] <= s1.value;
      end
   end

   always_comb begin
      for (int j = 0; j < cnv_pkg::KSIZE; j++) begin
         part_in[j] = '0;
         for (int k = 0; k < cnv_pkg::KSIZE; k++) begin
            part_in[j] = part_in[j]
                       + cnv_pkg::PART_W'(prod_ff[j*cnv_pkg::KSIZE + k]);
         end
      end
      sum_in = '0;
      for (int j = 0; j < cnv_pkg::KSIZE; j++) begin
         sum_in = sum_in + cnv_pkg::SUM_W'(part_ff[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < cnv_pkg::KAREA; i++) begin
            prod_ff[i] <= win_i[i] * kern_ff[i];
         end
         part_ff <= part_in;
         sum_ff  <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t2_ff <= '0;
         t3_ff <= '0;
         t4_ff <= '0;
         t5_ff <= '0;
      end else if (adv) begin
         t2_ff <= '{valid: s1.valid && s1.emit, out_row: s1.out_row, out_col: s1.out_col};
         t3_ff <= t2_ff;
         t4_ff <= t3_ff;
         t5_ff <= t4_ff;
      end
   end

   assign valid_o = t5_ff.valid;
   assign sum_o   = sum_ff;
   assign row_o   = t5_ff.out_row;
   assign col_o   = t5_ff.out_col;

endmodule

// File: rtl/core/conv2d_8x8_valid_stream.sv
// ----------------------------------------------------------------------------
// conv2d_8x8_valid_stream
// Streaming valid-region 8x8 correlation over a square image.
// ----------------------------------------------------------------------------
// req_ch carries transactions: opcode 0 loads coefficient coef_index,
// opcode 1 delivers the next pixel in raster order. rsp_ch returns the exact
// 38-bit window sum with the window's top-left row and column.
// csr_wr_en/csr_wr_data set image_size (saturated to 8..1024); write it only
// while the block is idle.
// One transaction is taken every cycle while rsp_ch is not stalled. The
// pixel that completes a window passes the input stage register, the window
// register, the multiplier stage and two adder tree stages to its response.
// Reset (synchronous) clears the raster counters and the pipeline valids and
// sets image_size to 8; kernel and line store hold nothing valid until
// written. When rsp_ch is stalled the whole pipeline holds and req_ch.ready
// drops; a response held in the output register does not block new
// transactions while the receiver is ready.
// ----------------------------------------------------------------------------
module conv2d_8x8_valid_stream (
   input  logic                             clock,
   input  logic                             reset,
   cnv_req_if.sink                          req_ch,
   cnv_rsp_if.source                        rsp_ch,
   input  logic                             csr_wr_en,
   input  logic [cnv_pkg::SIZE_W-1:0]       csr_wr_data
);

   logic [cnv_pkg::SIZE_W-1:0] size_ff, size_eff;
   logic [cnv_pkg::IDX_W-1:0]  col_ff, col_in, row_ff, row_in;
   logic [cnv_pkg::SIZE_W-1:0] c0, r0, c1, r1;
   logic                       adv, acc, pixel, emit;
   cnv_pkg::stage_type         s1_ff, s1_in;
   cnv_pkg::sample_type        win [cnv_pkg::KAREA];

   assign adv          = !rsp_ch.valid || rsp_ch.ready;
   assign req_ch.ready = adv;
   assign acc          = req_ch.valid && adv;
   assign pixel        = (req_ch.opcode == cnv_pkg::OP_PIXEL);

   always_comb begin
      priority if (size_ff < cnv_pkg::SIZE_MIN) begin
         size_eff = cnv_pkg::SIZE_MIN;
      end else if (size_ff > cnv_pkg::SIZE_MAX) begin
         size_eff = cnv_pkg::SIZE_MAX;
      end else begin
         size_eff = size_ff;
      end
   end

   always_comb begin
      c0 = {1'b0, col_ff};
      r0 = {1'b0, row_ff};
      if (c0 >= size_eff) begin
         c0 = '0;
         r0 = r0 + 1'b1;
      end
      if (r0 >= size_eff) begin
         r0 = '0;
      end
      emit = (r0 >= cnv_pkg::EDGE_LIM) && (c0 >= cnv_pkg::EDGE_LIM);
      c1 = c0 + 1'b1;
      r1 = r0;
      if (c1 >= size_eff) begin
         c1 = '0;
         r1 = r0 + 1'b1;
         if (r1 >= size_eff) begin
            r1 = '0;
         end
      end
      col_in = c1[cnv_pkg::IDX_W-1:0];
      row_in = r1[cnv_pkg::IDX_W-1:0];
   end

   always_comb begin
      s1_in.valid      = acc;
      s1_in.pixel      = pixel;
      s1_in.emit       = pixel && emit;
      s1_in.coef_index = req_ch.coef_index;
      s1_in.value      = req_ch.value;
      s1_in.col        = c0[cnv_pkg::ADDR_W-1:0];
      s1_in.out_row    = cnv_pkg::IDX_W'(r0 - cnv_pkg::EDGE_LIM);
      s1_in.out_col    = cnv_pkg::IDX_W'(c0 - cnv_pkg::EDGE_LIM);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= cnv_pkg::SIZE_RESET;
         col_ff  <= '0;
         row_ff  <= '0;
         s1_ff   <= '0;
      end else begin
         if (csr_wr_en) begin
            size_ff <= csr_wr_data;
         end
         if (acc && pixel) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (adv) begin
            s1_ff <= s1_in;
         end
      end
   end

   cnv_window u_window (
      .clock   (clock),
      .adv     (adv),
      .rd_addr (s1_in.col),
      .s1      (s1_ff),
      .win_o   (win)
   );

   cnv_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .s1      (s1_ff),
      .win_i   (win),
      .valid_o (rsp_ch.valid),
      .sum_o   (rsp_ch.sum),
      .row_o   (rsp_ch.out_row),
      .col_o   (rsp_ch.out_col)
   );

`ifndef SYNTHESIS
   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      (s1_ff.valid && s1_ff.pixel) |-> ({1'b0, s1_ff.col} < cnv_pkg::SIZE_MAX))
      else $error("column beyond line store");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |=> $stable(s1_ff))
      else $error("pipeline moved while response stalled");

   a_out_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.out_row <= 10'd1016 && rsp_ch.out_col <= 10'd1016))
      else $error("response coordinates out of range");
`endif

endmodule
